/* hw/rtl/mss_pkg.sv */
// Shared types and constants for the max subarray sum stream block.
package mss_pkg;

   localparam int DEF_MAX_LENGTH = 65536;
   localparam int DEF_VALUE_BITS = 16;

   localparam int SUM_BITS   = 32;
   localparam int INDEX_BITS = 16;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   // register index, taken from paddr[2]
   localparam logic REG_ALLOW_EMPTY = 1'b0;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] best_sum;
      logic [INDEX_BITS-1:0]      first_index;
      logic [INDEX_BITS-1:0]      last_index;
   } result_type;

endpackage

/* hw/rtl/max_subarray_sum_stream.sv */
// The result for the item marked last is formed combinationally and registered onto rsp_*.
// One item per clock while not stalled; the scan state loops through one add and compare.
// A result held by rsp_stall parks in a skid stage; req_stall rises only when it is full.
// Reset (synchronous, active high) clears the scan state, allow_empty and both output stages.
// Configuration: allow_empty at byte address 0; a mode change applies at the next sequence.
module max_subarray_sum_stream
   import mss_pkg::*;
#(
   parameter int MAX_LENGTH = DEF_MAX_LENGTH,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SUM_BITS-1:0]   rsp_best_sum,
   output logic [INDEX_BITS-1:0]        rsp_first_index,
   output logic [INDEX_BITS-1:0]        rsp_last_index,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_BITS-1:0]     paddr,
   input  logic [CSR_DATA_BITS-1:0]     pwdata,
   output logic [CSR_DATA_BITS-1:0]     prdata,
   output logic                         pready
);

   logic       allow_empty_ff;
   logic       fire;
   logic       new_valid;
   result_type new_result;
   logic       out_valid_ff, skid_valid_ff;
   result_type out_ff, skid_ff;
   logic       out_free;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_ALLOW_EMPTY) ?
                   {{(CSR_DATA_BITS-1){1'b0}}, allow_empty_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_empty_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready && paddr[2] == REG_ALLOW_EMPTY) begin
         allow_empty_ff <= pwdata[0];
      end
   end

   assign req_stall = skid_valid_ff;
   assign fire      = req_valid && !req_stall;

   mss_scan #(
      .MAX_LENGTH (MAX_LENGTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .value        (req_value),
      .last         (req_last),
      .allow_empty  (allow_empty_ff),
      .result_valid (new_valid),
      .result       (new_result)
   );

   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         // skid full means no item was accepted this cycle
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= new_valid;
         end
      end else if (new_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : new_result;
      end
      if (!out_free && new_valid) begin
         skid_ff <= new_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_best_sum    = out_ff.best_sum;
   assign rsp_first_index = out_ff.first_index;
   assign rsp_last_index  = out_ff.last_index;

endmodule

/* hw/rtl/mss_scan.sv */
// Running Kadane scan: per-item state update and result formation.
module mss_scan
   import mss_pkg::*;
#(
   parameter int MAX_LENGTH = DEF_MAX_LENGTH,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic signed [VALUE_BITS-1:0] value,
   input  logic                         last,
   input  logic                         allow_empty,
   output logic                         result_valid,
   output result_type                   result
);

   localparam int POS_BITS = $clog2(MAX_LENGTH);
   localparam logic [POS_BITS-1:0] POS_LIMIT = POS_BITS'(MAX_LENGTH - 1);
   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   logic [POS_BITS-1:0]        pos_ff, pos_in;
   logic signed [SUM_BITS-1:0] run_sum_ff, run_sum_in;
   logic [POS_BITS-1:0]        run_start_ff, run_start_in;
   logic signed [SUM_BITS-1:0] best_ff, best_in;
   logic [POS_BITS-1:0]        best_start_ff, best_start_in;
   logic [POS_BITS-1:0]        best_end_ff, best_end_in;

   logic signed [SUM_BITS-1:0] v_ext;
   logic signed [SUM_BITS:0]   sum_wide;
   logic signed [SUM_BITS-1:0] sum_sat;
   logic [POS_BITS+INDEX_BITS-1:0] first_wide, last_wide;

   assign v_ext    = SUM_BITS'(value);
   assign sum_wide = {run_sum_ff[SUM_BITS-1], run_sum_ff} + {v_ext[SUM_BITS-1], v_ext};

   always_comb begin
      if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         sum_sat = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_BITS-1:0];
      end
   end

   always_comb begin
      run_sum_in    = run_sum_ff;
      run_start_in  = run_start_ff;
      best_in       = best_ff;
      best_start_in = best_start_ff;
      best_end_in   = best_end_ff;
      if (pos_ff == '0) begin
         run_sum_in    = v_ext;
         run_start_in  = '0;
         best_start_in = '0;
         best_end_in   = '0;
         if (allow_empty && !(v_ext > 0)) begin
            best_in = '0;
         end else begin
            best_in = v_ext;
         end
      end else begin
         // a zero run sum keeps the run going
         if (run_sum_ff < 0) begin
            run_sum_in   = v_ext;
            run_start_in = pos_ff;
         end else begin
            run_sum_in = sum_sat;
         end
         if (run_sum_in > best_ff) begin
            best_in       = run_sum_in;
            best_start_in = run_start_in;
            best_end_in   = pos_ff;
         end
      end
      pos_in = (pos_ff != POS_LIMIT) ? pos_ff + 1'b1 : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && last)) begin
         pos_ff        <= '0;
         run_sum_ff    <= '0;
         run_start_ff  <= '0;
         best_ff       <= '0;
         best_start_ff <= '0;
         best_end_ff   <= '0;
      end else if (fire) begin
         pos_ff        <= pos_in;
         run_sum_ff    <= run_sum_in;
         run_start_ff  <= run_start_in;
         best_ff       <= best_in;
         best_start_ff <= best_start_in;
         best_end_ff   <= best_end_in;
      end
   end

   // indices report the low 16 bits of the position
   assign first_wide = {{INDEX_BITS{1'b0}}, best_start_in};
   assign last_wide  = {{INDEX_BITS{1'b0}}, best_end_in};

   assign result_valid       = fire && last;
   assign result.best_sum    = best_in;
   assign result.first_index = first_wide[INDEX_BITS-1:0];
   assign result.last_index  = last_wide[INDEX_BITS-1:0];

endmodule

/* bench/max_subarray_sum_stream_test.sv */
// Testbench for the streaming max subarray sum block: predictor-checked scan results.
`timescale 1ns / 1ps

module max_subarray_sum_stream_test;
   import mss_pkg::*;

   localparam int VB = DEF_VALUE_BITS;
   localparam int IDLE_PCT = 35;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 150;
   localparam int MAX_REPORTS = 10;

   localparam logic [CSR_ADDR_BITS-1:0] ADDR_ALLOW_EMPTY = {REG_ALLOW_EMPTY, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_SPARE = {~REG_ALLOW_EMPTY, 2'b00};
   localparam logic MODE_NONEMPTY = 1'b0;
   localparam logic MODE_EMPTY_OK = 1'b1;

   localparam logic signed [VB-1:0] VAL_MIN = -32768;
   localparam logic signed [VB-1:0] VAL_MAX = 32767;
   localparam longint SUM_HI = 64'sd2147483647;
   localparam longint SUM_LO = -64'sd2147483648;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [VB-1:0] req_value = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SUM_BITS-1:0] rsp_best_sum;
   logic [INDEX_BITS-1:0] rsp_first_index;
   logic [INDEX_BITS-1:0] rsp_last_index;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;

   max_subarray_sum_stream i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_value(req_value), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_best_sum(rsp_best_sum), .rsp_first_index(rsp_first_index),
      .rsp_last_index(rsp_last_index),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10ms;
      $display("TB_ERROR");
      $finish;
   end

   // scan state mirrored in the bench
   bit          mode_empty = MODE_NONEMPTY;
   longint      scan_run = 0;
   longint      scan_best = 0;
   int unsigned scan_run_start = 0;
   int unsigned scan_best_first = 0;
   int unsigned scan_best_last = 0;
   int unsigned scan_pos = 0;

   result_type expected_results[$];
   int error_count = 0;
   bit no_idle = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;

   function automatic void track_item(input logic signed [VB-1:0] v, input bit fin,
                                      output bit emits, output result_type res);
      longint sum_next;
      emits = 1'b0;
      res = '0;
      if (scan_pos == 0) begin
         scan_run = v;
         scan_run_start = 0;
         scan_best_first = 0;
         scan_best_last = 0;
         if (mode_empty == MODE_EMPTY_OK)
            scan_best = (v > 0) ? longint'(v) : 0;
         else
            scan_best = v;
      end else begin
         // a zero run sum keeps the run going
         if (scan_run < 0) begin
            scan_run = v;
            scan_run_start = scan_pos;
         end else begin
            sum_next = scan_run + v;
            scan_run = (sum_next > SUM_HI) ? SUM_HI : (sum_next < SUM_LO) ? SUM_LO : sum_next;
         end
         if (scan_run > scan_best) begin
            scan_best = scan_run;
            scan_best_first = scan_run_start;
            scan_best_last = scan_pos;
         end
      end
      if (scan_pos < DEF_MAX_LENGTH - 1)
         scan_pos++;
      if (fin) begin
         emits = 1'b1;
         res.best_sum = scan_best[SUM_BITS-1:0];
         res.first_index = scan_best_first[INDEX_BITS-1:0];
         res.last_index = scan_best_last[INDEX_BITS-1:0];
         scan_run = 0;
         scan_best = 0;
         scan_run_start = 0;
         scan_best_first = 0;
         scan_best_last = 0;
         scan_pos = 0;
      end
   endfunction

   task automatic flag_mismatch(input string what, input longint want, input longint got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
   endtask

   // receiver: random stall, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result: sum %0d first %0d last %0d at %0t",
                        rsp_best_sum, rsp_first_index, rsp_last_index, $realtime);
         end else begin
            want = expected_results.pop_front();
            if (rsp_best_sum !== want.best_sum)
               flag_mismatch("best_sum", want.best_sum, rsp_best_sum);
            if (rsp_first_index !== want.first_index)
               flag_mismatch("first_index", want.first_index, rsp_first_index);
            if (rsp_last_index !== want.last_index)
               flag_mismatch("last_index", want.last_index, rsp_last_index);
         end
      end
   end

   task automatic send_item(input logic signed [VB-1:0] v, input bit fin,
                            input bit use_typed, input result_type typed_res);
      bit emits;
      result_type predicted;
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last <= fin;
      do @(posedge clock); while (req_stall);
      track_item(v, fin, emits, predicted);
      if (emits)
         expected_results.push_back(use_typed ? typed_res : predicted);
   endtask

   // drop valid, let all results drain, then wait out the extra clocks
   task automatic wait_drained(input int extra);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // write a register, then read back the mode register
   task automatic set_register(input logic [CSR_ADDR_BITS-1:0] addr,
                               input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr[2] == REG_ALLOW_EMPTY)
         mode_empty = data[0];
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ADDR_ALLOW_EMPTY;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_BITS'(mode_empty))
         flag_mismatch("allow_empty readback", mode_empty, prdata);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   typedef struct packed {
      bit                         do_write;
      bit [CSR_ADDR_BITS-1:0]     waddr;
      bit [CSR_DATA_BITS-1:0]     wdata;
      bit signed [VB-1:0]         value;
      bit                         fin;
      bit                         typed;
      bit signed [SUM_BITS-1:0]   exp_sum;
      bit [INDEX_BITS-1:0]        exp_first;
      bit [INDEX_BITS-1:0]        exp_last;
   } step_row;

   localparam int DIRECTED_ROWS = 25;
   step_row directed_steps [DIRECTED_ROWS] = '{
      // single items at the extremes, reset mode then empty mode
      '{0, ADDR_ALLOW_EMPTY, 0, VAL_MIN, 1, 1, VAL_MIN, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, VAL_MAX, 1, 1, VAL_MAX, 0, 0},
      '{1, ADDR_ALLOW_EMPTY, MODE_EMPTY_OK, VAL_MIN, 1, 1, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, VAL_MAX, 1, 1, VAL_MAX, 0, 0},
      // empty form with no positive run
      '{0, ADDR_ALLOW_EMPTY, 0, -3, 0, 0, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, -1, 0, 0, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, -7, 0, 0, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, -2, 1, 1, 0, 0, 0},
      // same sequence, non-empty form
      '{1, ADDR_ALLOW_EMPTY, MODE_NONEMPTY, -3, 0, 0, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, -1, 0, 0, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, -7, 0, 0, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, -2, 1, 0, 0, 0, 0},
      // ties and a zero run sum
      '{0, ADDR_ALLOW_EMPTY, 0, 5, 0, 0, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, -5, 0, 0, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, 5, 0, 0, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, 0, 1, 0, 0, 0, 0},
      // write to the unused register slot must not change the mode
      '{1, ADDR_SPARE, 1, -4, 1, 1, -4, 0, 0},
      // mode change mid-sequence applies only to the next one
      '{0, ADDR_ALLOW_EMPTY, 0, -6, 0, 0, 0, 0, 0},
      '{1, ADDR_ALLOW_EMPTY, MODE_EMPTY_OK, -3, 0, 0, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, -1, 1, 0, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, -9, 1, 1, 0, 0, 0},
      '{1, ADDR_ALLOW_EMPTY, MODE_NONEMPTY, 0, 1, 1, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, 1, 0, 0, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, 2, 0, 0, 0, 0, 0},
      '{0, ADDR_ALLOW_EMPTY, 0, VAL_MIN, 1, 0, 0, 0, 0}
   };

   initial begin
      result_type typed_res;
      step_row row;
      logic signed [VB-1:0] v;
      int sent, len, style, kind;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         row = directed_steps[i];
         if (row.do_write) begin
            wait_drained(4);
            set_register(row.waddr, row.wdata);
         end
         typed_res.best_sum = row.exp_sum;
         typed_res.first_index = row.exp_first;
         typed_res.last_index = row.exp_last;
         send_item(row.value, row.fin, row.typed, typed_res);
      end

      for (int phase = 0; phase < 6; phase++) begin
         wait_drained(4);
         set_register(ADDR_ALLOW_EMPTY, ($urandom & ~32'd1) | CSR_DATA_BITS'(phase[0]));
         if ($urandom_range(1))
            set_register(ADDR_SPARE, $urandom);
         no_idle = (phase == 2);
         if (phase == 4)
            hold_request = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            kind = $urandom_range(9);
            if (phase == 4)
               len = $urandom_range(1, 2);
            else if (kind < 6)
               len = $urandom_range(1, 8);
            else if (kind < 9)
               len = $urandom_range(9, 40);
            else
               len = $urandom_range(41, 200);
            style = $urandom_range(3);
            for (int k = 0; k < len; k++) begin
               case (style)
                  0: v = VB'($urandom);
                  1: v = VB'(int'($urandom_range(16)) - 8);
                  2: begin
                     case ($urandom_range(4))
                        0: v = VAL_MIN;
                        1: v = VAL_MAX;
                        2: v = -1;
                        3: v = 0;
                        default: v = 1;
                     endcase
                  end
                  default: v = VB'(int'($urandom_range(400)) - 190);
               endcase
               send_item(v, k == len - 1, 1'b0, '0);
               sent++;
            end
         end
      end
      no_idle = 1'b0;

      wait_drained(10);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
